@@ rtl/rfv_pkg.sv @@
package rfv_pkg;

    localparam int unsigned RFV_FRAME_LIMIT = 32'd16777216;
    localparam int unsigned QDEPTH = 4;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_TRUNC_HDR = 4'd1;
    localparam logic [3:0] ERR_PAD_END   = 4'd2;
    localparam logic [3:0] ERR_SEQ_TWICE = 4'd3;
    localparam logic [3:0] ERR_SEQ_LATE  = 4'd4;
    localparam logic [3:0] ERR_BLK_EARLY = 4'd8;
    localparam logic [3:0] ERR_BLK_SHORT = 4'd9;
    localparam logic [3:0] ERR_BLK_END   = 4'd10;
    localparam logic [3:0] ERR_NO_SEQ    = 4'd11;
    localparam logic [3:0] ERR_TOO_LONG  = 4'd12;

    localparam int C_BLOCKS     = 0;
    localparam int C_PADS       = 1;
    localparam int C_PADBYTES   = 2;
    localparam int C_OVERSIZED  = 3;
    localparam int C_MISALIGNED = 4;
    localparam int C_OUTOFORDER = 5;
    localparam int C_LATECOARSE = 6;
    localparam int C_LATEOVER   = 7;

    localparam logic [2:0] LF_ORD_COARSE = 3'd1;
    localparam logic [2:0] LF_ORD_FINE   = 3'd2;
    localparam logic [2:0] LF_SEEN_FINE  = 3'd4;

    localparam logic [3:0] ST_VALID    = 4'd0;
    localparam logic [3:0] ST_ERROR    = 4'd1;
    localparam logic [3:0] ST_ERRPOS   = 4'd2;
    localparam logic [3:0] ST_WIDTH    = 4'd3;
    localparam logic [3:0] ST_HEIGHT   = 4'd4;
    localparam logic [3:0] ST_TOTAL    = 4'd5;
    localparam logic [3:0] ST_CHROMA   = 4'd6;
    localparam logic [3:0] ST_CRITICAL = 4'd15;

    localparam logic [1:0] REG_MAGIC = 2'd0;
    localparam logic [1:0] REG_SHARD = 2'd1;
    localparam logic [1:0] REG_HOFF  = 2'd2;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] shard;
        logic [7:0]  hoff;
    } t_cfg;

    typedef struct packed {
        logic        word_v;
        logic [31:0] word;
        logic        stats;
    } t_qent;

    typedef struct packed {
        logic            ok;
        logic [3:0]      err;
        logic [31:0]     epos;
        logic [14:0]     wid;
        logic [14:0]     hgt;
        logic [23:0]     tot;
        logic            chr;
        logic [7:0][31:0] cnt;
        logic [31:0]     crit;
    } t_view;

    function automatic logic [4:0] side_blocks(input logic [14:0] extent);
        logic [15:0] a;
        logic [15:0] s;
        begin
            a = ({1'b0, extent} + 16'd31) & 16'hffe0;
            if (a < 16'd128) begin
                a = 16'd128;
            end
            s = ((a >> 5) + 16'd31) >> 5;
            side_blocks = s[4:0];
        end
    endfunction

endpackage

@@ rtl/rfv_queue.sv @@
module rfv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfv_pkg::t_qent i_data,
    input  logic           i_pop,
    output rfv_pkg::t_qent o_head,
    output logic           o_empty,
    output logic           o_full
);
    import rfv_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    t_qent         r_mem [QDEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ rtl/rfv_front.sv @@
module rfv_front #(
    parameter int unsigned FRAME_LIMIT = rfv_pkg::RFV_FRAME_LIMIT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfv_pkg::t_cfg  i_cfg,
    input  logic           i_cfg_upd,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_word,
    input  logic [2:0]     i_bv,
    input  logic           i_last,
    input  logic           i_q_full,
    output logic           o_push,
    output rfv_pkg::t_qent o_qent,
    input  logic           i_done,
    output rfv_pkg::t_view o_view
);
    import rfv_pkg::*;

    localparam int PW = $clog2(FRAME_LIMIT + 1);
    localparam logic [PW:0] MAXV = (PW+1)'(FRAME_LIMIT);

    typedef enum logic [2:0] {PH_W0, PH_W1, PH_PAD, PH_BLK, PH_ERR} t_phase;

    t_phase         r_ph, n_ph;
    logic [PW-1:0]  r_pos, n_pos;
    logic [31:0]    r_left, n_left;
    logic [31:0]    r_w0, n_w0;
    logic [PW-1:0]  r_start, n_start;
    logic [15:0]    r_off, n_off;
    logic [15:0]    r_roff, n_roff;
    logic           r_norm, n_norm;
    logic [3:0]     r_err, n_err;
    logic [PW-1:0]  r_epos, n_epos;
    logic           r_hdr, n_hdr;
    logic [14:0]    r_wid, n_wid;
    logic [14:0]    r_hgt, n_hgt;
    logic [23:0]    r_tot, n_tot;
    logic           r_chr, n_chr;
    logic [11:0]    r_clim, n_clim;
    logic [23:0]    r_prev, n_prev;
    logic [2:0]     r_lf, n_lf;
    logic [PW-1:0]  r_cnt [8];
    logic [PW-1:0]  n_cnt [8];
    logic [PW-1:0]  r_crit, n_crit;
    logic           r_hold, n_hold;

    logic           acc;
    logic [2:0]     bv;
    logic [16:0]    stp;
    logic [35:0]    room;
    logic [35:0]    sz;
    logic [35:0]    ss36;
    logic           over;
    logic [11:0]    pwc;
    logic [23:0]    idx;
    logic           coarse;
    logic [1:0]     scode;
    logic [4:0]     sbw;
    logic [4:0]     sbh;
    logic [9:0]     sbp;
    logic [14:0]    nw;
    logic [14:0]    nh;

    assign o_ready = !r_hold && r_norm && !i_q_full && !i_cfg_upd;
    assign acc = i_valid && o_ready;

    always_comb begin
        n_ph = r_ph; n_pos = r_pos; n_left = r_left; n_w0 = r_w0; n_start = r_start;
        n_off = r_off; n_roff = r_roff; n_norm = r_norm; n_err = r_err; n_epos = r_epos;
        n_hdr = r_hdr; n_wid = r_wid; n_hgt = r_hgt; n_tot = r_tot; n_chr = r_chr;
        n_clim = r_clim; n_prev = r_prev; n_lf = r_lf; n_crit = r_crit; n_hold = r_hold;
        for (int i = 0; i < 8; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        o_push = 1'b0;
        o_qent = '0;
        bv = (!i_last || i_bv > 3'd4) ? 3'd4 : i_bv;
        ss36 = {20'd0, i_cfg.shard};
        room = 36'(MAXV) - 36'(r_start);
        sz = '0; over = 1'b0; coarse = 1'b0; scode = '0;
        pwc = '0; idx = '0; sbw = '0; sbh = '0; sbp = '0; nw = '0; nh = '0;
        stp = {1'b0, r_off} + 17'd4;
        for (int k = 0; k < 4; k++) begin
            if (i_cfg.shard != '0 && stp >= {1'b0, i_cfg.shard}) begin
                stp = stp - {1'b0, i_cfg.shard};
            end
        end

        if (!r_norm) begin
            if (i_cfg.shard != '0 && r_off >= i_cfg.shard) begin
                n_off = r_off - i_cfg.shard;
            end else begin
                n_norm = 1'b1;
            end
        end

        if (acc) begin
            if (r_ph != PH_ERR && ({1'b0, r_pos} + (PW+1)'(bv)) > MAXV) begin
                n_err = ERR_TOO_LONG; n_epos = r_pos; n_ph = PH_ERR;
            end
            if (n_ph != PH_ERR && bv == 3'd4) begin
                case (r_ph)
                    PH_W0: begin
                        n_start = r_pos; n_roff = r_off; n_w0 = i_word; n_ph = PH_W1;
                        if (i_word != i_cfg.magic) begin
                            o_push = 1'b1; o_qent.word_v = 1'b1; o_qent.word = i_word;
                        end
                    end
                    PH_W1: begin
                        if (r_w0 == i_cfg.magic) begin
                            sz = 36'd8 + {2'b00, i_word, 2'b00};
                            if (sz > room) begin
                                n_err = ERR_PAD_END; n_epos = r_start; n_ph = PH_ERR;
                            end else begin
                                n_cnt[C_PADS] = r_cnt[C_PADS] + 1'b1;
                                n_cnt[C_PADBYTES] = r_cnt[C_PADBYTES] + sz[PW-1:0];
                                if (i_cfg.shard != '0) begin
                                    if (sz + 36'd8 > ss36) begin
                                        n_cnt[C_OVERSIZED] = r_cnt[C_OVERSIZED] + 1'b1;
                                    end else if (36'(r_roff) + sz > ss36) begin
                                        n_cnt[C_MISALIGNED] = r_cnt[C_MISALIGNED] + 1'b1;
                                    end
                                end
                                n_left = i_word;
                                n_ph = (i_word != '0) ? PH_PAD : PH_W0;
                            end
                        end else if (r_w0[31]) begin
                            scode = i_word[25:24];
                            if (r_hdr) begin
                                n_err = ERR_SEQ_TWICE; n_epos = r_start; n_ph = PH_ERR;
                            end else if (r_cnt[C_BLOCKS] != '0) begin
                                n_err = ERR_SEQ_LATE; n_epos = r_start; n_ph = PH_ERR;
                            end else if (scode != 2'd0) begin
                                n_err = ERR_SEQ_LATE + {2'b00, scode};
                                n_epos = r_start; n_ph = PH_ERR;
                            end else begin
                                nw = {1'b0, r_w0[13:0]} + 15'd1;
                                nh = {1'b0, r_w0[27:14]} + 15'd1;
                                sbw = side_blocks(nw);
                                sbh = side_blocks(nh);
                                sbp = sbw * sbh;
                                n_hdr = 1'b1; n_wid = nw; n_hgt = nh;
                                n_tot = i_word[23:0]; n_chr = i_word[26];
                                n_clim = 12'({sbp, 3'b000} + {1'b0, sbp, 2'b00});
                                n_crit = r_start + PW'(8);
                                if (i_cfg.shard != '0) begin
                                    if (36'd16 > ss36) begin
                                        n_cnt[C_OVERSIZED] = r_cnt[C_OVERSIZED] + 1'b1;
                                    end else if (36'(r_roff) + 36'd8 > ss36) begin
                                        n_cnt[C_MISALIGNED] = r_cnt[C_MISALIGNED] + 1'b1;
                                    end
                                end
                                n_ph = PH_W0;
                                o_push = 1'b1; o_qent.word_v = 1'b1; o_qent.word = i_word;
                            end
                        end else begin
                            pwc = r_w0[27:16];
                            sz = {22'd0, pwc, 2'b00};
                            idx = i_word[31:8];
                            if (!r_hdr) begin
                                n_err = ERR_BLK_EARLY; n_epos = r_start; n_ph = PH_ERR;
                            end else if (pwc < 12'd2) begin
                                n_err = ERR_BLK_SHORT; n_epos = r_start; n_ph = PH_ERR;
                            end else if (sz > room) begin
                                n_err = ERR_BLK_END; n_epos = r_start; n_ph = PH_ERR;
                            end else begin
                                if (r_cnt[C_BLOCKS] != '0 && idx < r_prev) begin
                                    n_cnt[C_OUTOFORDER] = r_cnt[C_OUTOFORDER] + 1'b1;
                                end
                                n_prev = idx;
                                n_cnt[C_BLOCKS] = r_cnt[C_BLOCKS] + 1'b1;
                                if (i_cfg.shard != '0) begin
                                    coarse = idx < {12'd0, r_clim};
                                    if (coarse && (r_lf & LF_SEEN_FINE) != '0) begin
                                        n_cnt[C_LATECOARSE] = r_cnt[C_LATECOARSE] + 1'b1;
                                    end
                                    over = (sz + 36'd8 > ss36);
                                    if (over) begin
                                        n_cnt[C_OVERSIZED] = r_cnt[C_OVERSIZED] + 1'b1;
                                        if ((r_lf & (coarse ? LF_ORD_COARSE : LF_ORD_FINE))
                                            != '0) begin
                                            n_cnt[C_LATEOVER] = r_cnt[C_LATEOVER] + 1'b1;
                                        end
                                    end else begin
                                        if (36'(r_roff) + sz > ss36) begin
                                            n_cnt[C_MISALIGNED] = r_cnt[C_MISALIGNED] + 1'b1;
                                        end
                                        n_lf = n_lf | (coarse ? LF_ORD_COARSE : LF_ORD_FINE);
                                    end
                                    if (!coarse) begin
                                        n_lf = n_lf | LF_SEEN_FINE;
                                    end else begin
                                        n_crit = r_start + sz[PW-1:0];
                                    end
                                end
                                n_left = {20'd0, pwc - 12'd2};
                                n_ph = (pwc != 12'd2) ? PH_BLK : PH_W0;
                                o_push = 1'b1; o_qent.word_v = 1'b1; o_qent.word = i_word;
                            end
                        end
                    end
                    PH_PAD: begin
                        n_left = r_left - 1'b1;
                        if (r_left == 32'd1) begin
                            n_ph = PH_W0;
                        end
                    end
                    PH_BLK: begin
                        o_push = 1'b1; o_qent.word_v = 1'b1; o_qent.word = i_word;
                        n_left = r_left - 1'b1;
                        if (r_left == 32'd1) begin
                            n_ph = PH_W0;
                        end
                    end
                    default: begin
                    end
                endcase
                n_pos = r_pos + PW'(4);
                n_off = stp[15:0];
            end

            if (i_last) begin
                if (n_ph != PH_ERR) begin
                    if (bv != 3'd0 && bv != 3'd4 && n_ph == PH_W0) begin
                        n_err = ERR_TRUNC_HDR; n_epos = n_pos; n_ph = PH_ERR;
                    end else if (n_ph == PH_W1) begin
                        n_err = ERR_TRUNC_HDR; n_epos = n_start; n_ph = PH_ERR;
                    end else if (n_ph == PH_PAD) begin
                        n_err = ERR_PAD_END; n_epos = n_start; n_ph = PH_ERR;
                    end else if (n_ph == PH_BLK) begin
                        n_err = ERR_BLK_END; n_epos = n_start; n_ph = PH_ERR;
                    end else if (!n_hdr) begin
                        n_err = ERR_NO_SEQ; n_epos = '0; n_ph = PH_ERR;
                    end
                end
                o_push = 1'b1;
                o_qent.stats = 1'b1;
                n_hold = 1'b1;
            end
        end

        if (i_done) begin
            n_ph = PH_W0; n_pos = '0; n_left = '0; n_w0 = '0; n_start = '0;
            n_err = ERR_NONE; n_epos = '0; n_hdr = 1'b0; n_wid = '0; n_hgt = '0;
            n_tot = '0; n_chr = 1'b0; n_clim = '0; n_prev = '0; n_lf = '0;
            n_crit = '0; n_hold = 1'b0;
            for (int i = 0; i < 8; i++) begin
                n_cnt[i] = '0;
            end
        end
        if (i_done || i_cfg_upd) begin
            n_off = {8'd0, i_cfg.hoff};
            n_roff = '0;
            n_norm = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_W0; r_pos <= '0; r_left <= '0; r_w0 <= '0; r_start <= '0;
            r_off <= '0; r_roff <= '0; r_norm <= 1'b0; r_err <= ERR_NONE; r_epos <= '0;
            r_hdr <= 1'b0; r_wid <= '0; r_hgt <= '0; r_tot <= '0; r_chr <= 1'b0;
            r_clim <= '0; r_prev <= '0; r_lf <= '0; r_crit <= '0; r_hold <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_ph <= n_ph; r_pos <= n_pos; r_left <= n_left; r_w0 <= n_w0;
            r_start <= n_start; r_off <= n_off; r_roff <= n_roff; r_norm <= n_norm;
            r_err <= n_err; r_epos <= n_epos; r_hdr <= n_hdr; r_wid <= n_wid;
            r_hgt <= n_hgt; r_tot <= n_tot; r_chr <= n_chr; r_clim <= n_clim;
            r_prev <= n_prev; r_lf <= n_lf; r_crit <= n_crit; r_hold <= n_hold;
            for (int i = 0; i < 8; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_comb begin
        o_view = '0;
        o_view.ok = (r_ph != PH_ERR);
        o_view.err = r_err;
        o_view.epos = 32'(r_epos);
        if (r_ph != PH_ERR) begin
            o_view.wid = r_wid;
            o_view.hgt = r_hgt;
            o_view.tot = r_tot;
            o_view.chr = r_chr;
            o_view.crit = 32'(r_crit);
            for (int i = 0; i < 8; i++) begin
                o_view.cnt[i] = 32'(r_cnt[i]);
            end
        end
    end
endmodule

@@ rtl/rfv_back.sv @@
module rfv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfv_pkg::t_qent i_head,
    input  logic           i_empty,
    output logic           o_pop,
    input  rfv_pkg::t_view i_view,
    output logic           o_done,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic           o_kind,
    output logic [3:0]     o_sid,
    output logic [31:0]    o_value,
    output logic           o_tlast
);
    import rfv_pkg::*;

    typedef enum logic {S_IDLE, S_STAT} t_state;

    t_state      r_st, n_st;
    logic        r_tvalid, n_tvalid;
    logic        r_kind, n_kind;
    logic [3:0]  r_sid, n_sid;
    logic [31:0] r_val, n_val;
    logic        r_last, n_last;
    logic [3:0]  r_idx, n_idx;
    logic        r_done, n_done;
    logic        free;
    logic [31:0] sval;

    assign free = !r_tvalid || i_tready;
    assign o_pop = (r_st == S_IDLE) && free && !i_empty;
    assign o_tvalid = r_tvalid;
    assign o_kind = r_kind;
    assign o_sid = r_sid;
    assign o_value = r_val;
    assign o_tlast = r_last;
    assign o_done = r_done;

    always_comb begin
        case (r_idx)
            ST_VALID:    sval = {31'd0, i_view.ok};
            ST_ERROR:    sval = {28'd0, i_view.err};
            ST_ERRPOS:   sval = i_view.epos;
            ST_WIDTH:    sval = {17'd0, i_view.wid};
            ST_HEIGHT:   sval = {17'd0, i_view.hgt};
            ST_TOTAL:    sval = {8'd0, i_view.tot};
            ST_CHROMA:   sval = {31'd0, i_view.chr};
            ST_CRITICAL: sval = i_view.crit;
            default:     sval = i_view.cnt[3'(r_idx - 4'd7)];
        endcase
    end

    always_comb begin
        n_st = r_st; n_tvalid = r_tvalid; n_kind = r_kind; n_sid = r_sid;
        n_val = r_val; n_last = r_last; n_idx = r_idx; n_done = 1'b0;
        if (free) begin
            n_tvalid = 1'b0;
        end
        case (r_st)
            S_IDLE: begin
                if (o_pop) begin
                    if (i_head.word_v) begin
                        n_tvalid = 1'b1; n_kind = 1'b0; n_sid = '0;
                        n_val = i_head.word; n_last = 1'b0;
                    end
                    if (i_head.stats) begin
                        n_st = S_STAT;
                        n_idx = '0;
                    end
                end
            end
            S_STAT: begin
                if (free) begin
                    n_tvalid = 1'b1; n_kind = 1'b1; n_sid = r_idx; n_val = sval;
                    n_last = (r_idx == ST_CRITICAL);
                    n_idx = r_idx + 1'b1;
                    if (r_idx == ST_CRITICAL) begin
                        n_done = 1'b1;
                        n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_tvalid <= 1'b0; r_kind <= 1'b0; r_sid <= '0;
            r_val <= '0; r_last <= 1'b0; r_idx <= '0; r_done <= 1'b0;
        end else begin
            r_st <= n_st; r_tvalid <= n_tvalid; r_kind <= n_kind; r_sid <= n_sid;
            r_val <= n_val; r_last <= n_last; r_idx <= n_idx; r_done <= n_done;
        end
    end
endmodule

@@ rtl/record_frame_validator_top.sv @@
// Channel   Dir  Handshake            Payload
// s         in   i_s_tvalid/o_s_tready tdata: word, bytes_valid; tlast: last
// m         out  o_m_tvalid/i_m_tready tdata: stat_id, value; tuser: kind; tlast
// apb       in   psel/penable/pready   pad magic, shard size, header offset
//
// One frame word per cycle while the queue is not full; each request yields at most
// one stripped word. After the last word of a frame, input is held until the last of
// its sixteen statistics has been loaded into the output register.
// After reset, a config write or a frame end, input waits while the header offset is
// reduced modulo shard_size, one subtract per cycle.
// Output is registered; a four-entry queue decouples parsing from output stalls.
module record_frame_validator_top #(
    parameter int unsigned FRAME_LIMIT = rfv_pkg::RFV_FRAME_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // word[31:0], bytes_valid[34:32], zero pad
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // stat_id[3:0], value[35:4], zero pad
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rfv_pkg::*;

    t_cfg        r_cfg;
    logic        r_upd;
    logic        wr;
    t_qent       qin;
    t_qent       qhead;
    logic        push;
    logic        pop;
    logic        qempty;
    logic        qfull;
    logic        done;
    t_view       view;
    logic [3:0]  sid;
    logic [31:0] val;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_MAGIC: prdata = r_cfg.magic;
            REG_SHARD: prdata = {16'd0, r_cfg.shard};
            REG_HOFF:  prdata = {24'd0, r_cfg.hoff};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_upd <= 1'b0;
        end else begin
            r_upd <= wr;
            if (wr) begin
                case (paddr[3:2])
                    REG_MAGIC: r_cfg.magic <= pwdata;
                    REG_SHARD: r_cfg.shard <= pwdata[15:0];
                    REG_HOFF:  r_cfg.hoff <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    rfv_front #(.FRAME_LIMIT(FRAME_LIMIT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_cfg_upd(r_upd),
        .i_valid(i_s_tvalid), .o_ready(o_s_tready), .i_word(i_s_tdata[31:0]),
        .i_bv(i_s_tdata[34:32]), .i_last(i_s_tlast), .i_q_full(qfull),
        .o_push(push), .o_qent(qin), .i_done(done), .o_view(view)
    );

    rfv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(qin),
        .i_pop(pop), .o_head(qhead), .o_empty(qempty), .o_full(qfull)
    );

    rfv_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(qhead), .i_empty(qempty),
        .o_pop(pop), .i_view(view), .o_done(done), .o_tvalid(o_m_tvalid),
        .i_tready(i_m_tready), .o_kind(o_m_tuser), .o_sid(sid), .o_value(val),
        .o_tlast(o_m_tlast)
    );

    assign o_m_tdata = {4'd0, val, sid};
endmodule
